// ----- hw/rtl/cqt_pkg.sv -----
package cqt_pkg;

  // Sizing of the node and of its pending-proposal table.
  localparam int unsigned MaxNodes   = 16;
  localparam int unsigned TableDepth = 16;

  // Field widths fixed by the message format.
  localparam int unsigned WordW   = 32;
  localparam int unsigned NodeW   = 4;
  localparam int unsigned NodesW  = 5;
  localparam int unsigned AckW    = 5;
  localparam int unsigned ActW    = 4;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 2;

  // Table addressing.
  localparam int unsigned SlotW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned EntryW = 2 * WordW + AckW;

  // Remainder unit: quotient bits retired per cycle and steps per pass.
  localparam int unsigned DigitBits = 4;
  localparam int unsigned DivSteps  = WordW / DigitBits;
  localparam int unsigned CntW      = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  // Register reset values.
  localparam logic [WordW-1:0]  ProposeReset = WordW'(42);
  localparam logic [NodesW-1:0] NodesReset   = NodesW'(1);

  typedef enum logic [OpW-1:0] {
    OP_TICK     = 2'd0,
    OP_PROPOSAL = 2'd1,
    OP_ACCEPT   = 2'd2,
    OP_DECISION = 2'd3
  } op_e;

  typedef enum logic [ActW-1:0] {
    ACT_IDLE              = 4'd0,
    ACT_BCAST_PROPOSAL    = 4'd1,
    ACT_SEND_ACCEPT       = 4'd2,
    ACT_ACK_COUNTED       = 4'd3,
    ACT_BCAST_DECISION    = 4'd4,
    ACT_DECISION_RECORDED = 4'd5,
    ACT_DROP_PROPOSER     = 4'd6,
    ACT_DROP_TARGET       = 4'd7,
    ACT_DROP_UNKNOWN      = 4'd8
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_ID       = 2'd0,
    CFG_NUM_NODES     = 2'd1,
    CFG_PROPOSE_VALUE = 2'd2
  } cfg_idx_e;

  // Results of one pass of the remainder unit.
  typedef struct packed {
    logic [NodesW-1:0] turn;
    logic [SlotW-1:0]  slot;
  } div_res_t;

  // One pending proposal as held in the table memory.
  typedef struct packed {
    logic [WordW-1:0] id;
    logic [WordW-1:0] value;
    logic [AckW-1:0]  acks;
  } entry_t;

endpackage

// ----- hw/rtl/cqt_ram.sv -----
module cqt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cqt_divider.sv -----
module cqt_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cqt_pkg::WordW-1:0]      now_i,
  input  logic [cqt_pkg::WordW-1:0]      key_i,
  input  logic [cqt_pkg::NodesW-1:0]     nodes_i,
  output logic                           done_o,
  output cqt_pkg::div_res_t              res_o
);

  localparam int unsigned NW = cqt_pkg::NodesW;
  localparam int unsigned SW = cqt_pkg::SlotW;
  localparam int unsigned WW = cqt_pkg::WordW;
  localparam int unsigned DB = cqt_pkg::DigitBits;

  logic                         busy_q, busy_d;
  logic [cqt_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [WW-1:0]                now_q, now_d;
  logic [WW-1:0]                key_q, key_d;
  logic [NW-1:0]                turn_q, turn_d;
  logic [SW-1:0]                slot_q, slot_d;
  logic                         last;

  assign last = (cnt_q == cqt_pkg::CntW'(cqt_pkg::DivSteps - 1));

  // Two remainder lanes share the sequencing: time by cluster size and
  // proposal id by table depth. Each cycle retires DigitBits dividend bits
  // with a restoring compare and subtract per bit.
  always_comb begin
    logic [NW:0] r1;
    logic [SW:0] r2;
    r1     = {1'b0, turn_q};
    r2     = {1'b0, slot_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    now_d  = now_q;
    key_d  = key_q;
    for (int i = 0; i < DB; i++) begin
      r1 = {r1[NW-1:0], now_q[WW-1-i]};
      if (r1 >= {1'b0, nodes_i}) begin
        r1 = r1 - {1'b0, nodes_i};
      end
      r2 = {r2[SW-1:0], key_q[WW-1-i]};
      if (r2 >= (SW+1)'(cqt_pkg::TableDepth)) begin
        r2 = r2 - (SW+1)'(cqt_pkg::TableDepth);
      end
    end
    turn_d = turn_q;
    slot_d = slot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      now_d  = now_i;
      key_d  = key_i;
      turn_d = '0;
      slot_d = '0;
    end else if (busy_q) begin
      cnt_d  = cnt_q + 1'b1;
      now_d  = now_q << DB;
      key_d  = key_q << DB;
      turn_d = r1[NW-1:0];
      slot_d = r2[SW-1:0];
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    now_q  <= now_d;
    key_q  <= key_d;
    turn_q <= turn_d;
    slot_q <= slot_d;
  end

  assign done_o     = busy_q && last;
  assign res_o.turn = turn_q;
  assign res_o.slot = slot_q;

endmodule

// ----- hw/rtl/consensus_quorum_tracker_top.sv -----
// Quorum tracker for one node of a rotating-leader consensus cluster. Each
// accepted beat is a tick, a proposal, an accept or a decision and yields
// exactly one result beat. A new item is taken only once the last one has
// loaded its result into the output register. On the way there an item
// passes through the shared remainder unit, which retires four bits per
// cycle of both now_ms mod the cluster size and the proposal id (for a
// tick, the next id) mod the table depth, then the registered read of the
// pending-proposal table, and last the step that updates the table and
// loads the result. in_stall_o stays high while an item is in
// work; a finished result may wait in the output register while the next
// item is taken. Pending-entry valid bits live in flip-flops cleared by
// reset, so there is no clearing pass. The configuration port is always
// ready and is to be written only while the block is idle.
module consensus_quorum_tracker_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cqt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [cqt_pkg::WordW-1:0]         cfg_data_i,
  // Input channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cqt_pkg::OpW-1:0]           operation_i,
  input  logic [cqt_pkg::WordW-1:0]         now_ms_i,
  input  logic [cqt_pkg::NodeW-1:0]         sender_id_i,
  input  logic [cqt_pkg::NodeW-1:0]         target_node_i,
  input  logic [cqt_pkg::WordW-1:0]         msg_proposal_id_i,
  input  logic [cqt_pkg::WordW-1:0]         msg_value_i,
  input  logic [cqt_pkg::WordW-1:0]         msg_time_i,
  // Output channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [cqt_pkg::ActW-1:0]          action_o,
  output logic [cqt_pkg::NodeW-1:0]         dest_node_o,
  output logic [cqt_pkg::WordW-1:0]         out_proposal_id_o,
  output logic [cqt_pkg::WordW-1:0]         out_value_o,
  output logic [cqt_pkg::WordW-1:0]         stamp_ms_o,
  output logic [cqt_pkg::AckW-1:0]          ack_total_o,
  output logic                              entry_found_o
);

  localparam int unsigned WW = cqt_pkg::WordW;
  localparam int unsigned NW = cqt_pkg::NodeW;
  localparam int unsigned SW = cqt_pkg::SlotW;
  localparam int unsigned AW = cqt_pkg::AckW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_READ = 4'b0100,
    S_EXEC = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [NW-1:0]               node_id_q;
  logic [cqt_pkg::NodesW-1:0]  num_nodes_q;
  logic [WW-1:0]               propose_value_q;

  // Protocol state.
  logic [WW-1:0]                  next_id_q, next_id_d;
  logic [cqt_pkg::TableDepth-1:0] slot_valid_q, slot_valid_d;

  // Captured item.
  cqt_pkg::op_e  op_q;
  logic [WW-1:0] now_q, mid_q, mval_q, mtime_q;
  logic [NW-1:0] sender_q, target_q;

  // Output register.
  logic                       out_valid_q;
  logic [cqt_pkg::ActW-1:0]   action_q, action_d;
  logic [NW-1:0]              dest_q, dest_d;
  logic [WW-1:0]              pid_q, pid_d;
  logic [WW-1:0]              val_q, val_d;
  logic [WW-1:0]              stamp_q, stamp_d;
  logic [AW-1:0]              acks_q, acks_d;
  logic                       found_q, found_d;

  logic                       in_fire, fire;
  logic [cqt_pkg::NodesW-1:0] nodes;
  logic                       div_done;
  cqt_pkg::div_res_t          div_res;
  logic [WW-1:0]              div_key;
  cqt_pkg::entry_t            rd_entry, wr_entry;
  logic [cqt_pkg::EntryW-1:0] ram_rdata;
  logic                       wr_req;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign fire        = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  // Effective cluster size: zero counts as one, the top is clamped.
  always_comb begin
    if (num_nodes_q == '0) begin
      nodes = cqt_pkg::NodesW'(1);
    end else if (32'(num_nodes_q) > 32'(cqt_pkg::MaxNodes)) begin
      nodes = cqt_pkg::NodesW'(cqt_pkg::MaxNodes);
    end else begin
      nodes = num_nodes_q;
    end
  end

  // A tick works on the slot of the next id, messages on the carried id.
  assign div_key = (cqt_pkg::op_e'(operation_i) == cqt_pkg::OP_TICK) ? next_id_q
                                                                     : msg_proposal_id_i;

  cqt_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .now_i   (now_ms_i),
    .key_i   (div_key),
    .nodes_i (nodes),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  cqt_ram #(
    .Width (cqt_pkg::EntryW),
    .Depth (cqt_pkg::TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (fire && wr_req),
    .waddr_i (div_res.slot),
    .wdata_i (wr_entry),
    .re_i    (state_q == S_READ),
    .raddr_i (div_res.slot),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = cqt_pkg::entry_t'(ram_rdata);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_READ;
      S_READ: state_d = S_EXEC;
      S_EXEC: if (fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Protocol step: decide the action and the table update for this item.
  always_comb begin
    logic          match;
    logic          my_turn;
    logic          sender_turn;
    logic [AW-1:0] acks_inc;
    match       = slot_valid_q[div_res.slot] && (rd_entry.id == mid_q);
    my_turn     = ({1'b0, node_id_q} == div_res.turn);
    sender_turn = ({1'b0, sender_q} == div_res.turn);
    acks_inc    = rd_entry.acks + AW'(1);

    action_d     = cqt_pkg::ACT_IDLE;
    dest_d       = '0;
    pid_d        = '0;
    val_d        = '0;
    stamp_d      = '0;
    acks_d       = '0;
    found_d      = 1'b0;
    next_id_d    = next_id_q;
    slot_valid_d = slot_valid_q;
    wr_req       = 1'b0;
    wr_entry     = rd_entry;

    unique case (op_q)
      cqt_pkg::OP_TICK: begin
        if (my_turn) begin
          action_d                   = cqt_pkg::ACT_BCAST_PROPOSAL;
          pid_d                      = next_id_q;
          val_d                      = propose_value_q;
          stamp_d                    = now_q;
          next_id_d                  = next_id_q + WW'(1);
          slot_valid_d[div_res.slot] = 1'b1;
          wr_req                     = 1'b1;
          wr_entry.id                = next_id_q;
          wr_entry.value             = propose_value_q;
          wr_entry.acks              = '0;
        end
      end
      cqt_pkg::OP_PROPOSAL: begin
        pid_d = mid_q;
        if (!sender_turn) begin
          action_d = cqt_pkg::ACT_DROP_PROPOSER;
        end else begin
          action_d = cqt_pkg::ACT_SEND_ACCEPT;
          dest_d   = sender_q;
          val_d    = mval_q;
          stamp_d  = now_q;
        end
      end
      cqt_pkg::OP_ACCEPT: begin
        pid_d = mid_q;
        if (target_q != node_id_q) begin
          action_d = cqt_pkg::ACT_DROP_TARGET;
        end else if (!match) begin
          action_d = cqt_pkg::ACT_DROP_UNKNOWN;
        end else begin
          acks_d        = acks_inc;
          val_d         = rd_entry.value;
          wr_req        = 1'b1;
          wr_entry.acks = acks_inc;
          // Quorum is half the cluster, rounded down.
          if (acks_inc >= (nodes >> 1)) begin
            action_d                   = cqt_pkg::ACT_BCAST_DECISION;
            stamp_d                    = now_q;
            slot_valid_d[div_res.slot] = 1'b0;
          end else begin
            action_d = cqt_pkg::ACT_ACK_COUNTED;
          end
        end
      end
      cqt_pkg::OP_DECISION: begin
        action_d = cqt_pkg::ACT_DECISION_RECORDED;
        pid_d    = mid_q;
        val_d    = mval_q;
        stamp_d  = mtime_q;
        if (match) begin
          slot_valid_d[div_res.slot] = 1'b0;
          found_d                    = 1'b1;
        end
      end
      default: begin
        action_d = cqt_pkg::ACT_IDLE;
      end
    endcase
  end

  // Control state, configuration and protocol state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      node_id_q       <= '0;
      num_nodes_q     <= cqt_pkg::NodesReset;
      propose_value_q <= cqt_pkg::ProposeReset;
      next_id_q       <= '0;
      slot_valid_q    <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        priority if (cfg_index_i == cqt_pkg::CFG_NODE_ID) begin
          node_id_q <= cfg_data_i[NW-1:0];
        end else if (cfg_index_i == cqt_pkg::CFG_NUM_NODES) begin
          num_nodes_q <= cfg_data_i[cqt_pkg::NodesW-1:0];
        end else if (cfg_index_i == cqt_pkg::CFG_PROPOSE_VALUE) begin
          propose_value_q <= cfg_data_i;
        end else begin
          node_id_q <= node_id_q;
        end
      end
      if (fire) begin
        next_id_q    <= next_id_d;
        slot_valid_q <= slot_valid_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q     <= cqt_pkg::op_e'(operation_i);
      now_q    <= now_ms_i;
      sender_q <= sender_id_i;
      target_q <= target_node_i;
      mid_q    <= msg_proposal_id_i;
      mval_q   <= msg_value_i;
      mtime_q  <= msg_time_i;
    end
    if (fire) begin
      action_q <= action_d;
      dest_q   <= dest_d;
      pid_q    <= pid_d;
      val_q    <= val_d;
      stamp_q  <= stamp_d;
      acks_q   <= acks_d;
      found_q  <= found_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign action_o          = action_q;
  assign dest_node_o       = dest_q;
  assign out_proposal_id_o = pid_q;
  assign out_value_o       = val_q;
  assign stamp_ms_o        = stamp_q;
  assign ack_total_o       = acks_q;
  assign entry_found_o     = found_q;

endmodule

// ----- hw/rtl/cqt_checker.sv -----
module cqt_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [cqt_pkg::ActW-1:0]     action_o,
  input logic [cqt_pkg::NodeW-1:0]    dest_node_o,
  input logic [cqt_pkg::WordW-1:0]    out_proposal_id_o,
  input logic [cqt_pkg::WordW-1:0]    out_value_o,
  input logic [cqt_pkg::WordW-1:0]    stamp_ms_o,
  input logic [cqt_pkg::AckW-1:0]     ack_total_o,
  input logic                         entry_found_o
);

  // A stalled result beat holds its action, proposal id, value and stamp.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o)
      && $stable(out_proposal_id_o) && $stable(out_value_o) && $stable(stamp_ms_o))
    else $error("result beat changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // An off-turn tick reports nothing but zeros.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == cqt_pkg::ACT_IDLE) |->
      (dest_node_o == '0) && (out_proposal_id_o == '0) && (out_value_o == '0)
      && (stamp_ms_o == '0) && (ack_total_o == '0))
    else $error("idle result carries data");

  // Only a recorded decision can report a freed entry.
  a_found_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_found_o |-> (action_o == cqt_pkg::ACT_DECISION_RECORDED))
    else $error("entry found on a non-decision result");

  // Acks are reported only for counted acks and decisions.
  a_acks_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ack_total_o != '0) |->
      (action_o == cqt_pkg::ACT_ACK_COUNTED) || (action_o == cqt_pkg::ACT_BCAST_DECISION))
    else $error("ack total on an unrelated result");

endmodule

bind consensus_quorum_tracker_top cqt_checker u_cqt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .action_o          (action_o),
  .dest_node_o       (dest_node_o),
  .out_proposal_id_o (out_proposal_id_o),
  .out_value_o       (out_value_o),
  .stamp_ms_o        (stamp_ms_o),
  .ack_total_o       (ack_total_o),
  .entry_found_o     (entry_found_o)
);

// ----- tb/consensus_quorum_tracker_top_tb.sv -----
`timescale 1ns / 1ps

module consensus_quorum_tracker_top_tb;
  import cqt_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 14;
  localparam int unsigned PhaseItems = 145;
  localparam int unsigned MaxPrinted = 30;

  // One input beat and one result beat, field for field.
  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] now_ms;
    logic [NodeW-1:0] sender_id;
    logic [NodeW-1:0] target_node;
    logic [WordW-1:0] msg_proposal_id;
    logic [WordW-1:0] msg_value;
    logic [WordW-1:0] msg_time;
  } msg_item_t;

  typedef struct packed {
    action_e           action;
    logic [NodeW-1:0]  dest_node;
    logic [WordW-1:0]  proposal_id;
    logic [WordW-1:0]  value;
    logic [WordW-1:0]  stamp_ms;
    logic [AckW-1:0]   ack_total;
    logic              entry_found;
  } node_result_t;

  // Tracks the node's proposal table and predicts the action of each beat.
  class quorum_scoreboard;
    logic [NodeW-1:0]  node_id;
    logic [NodesW-1:0] num_nodes;
    logic [WordW-1:0]  propose_value;
    logic [WordW-1:0]  next_id;
    logic              slot_valid[TableDepth];
    logic [WordW-1:0]  slot_id[TableDepth];
    logic [WordW-1:0]  slot_value[TableDepth];
    logic [AckW-1:0]   slot_acks[TableDepth];
    node_result_t      action_q[$];
    int unsigned       mismatches;
    int unsigned       results_seen;
    int unsigned       freed_by_decision;
    int unsigned       action_seen[9];

    function new();
      node_id = '0;
      num_nodes = NodesReset;
      propose_value = ProposeReset;
      next_id = '0;
      for (int i = 0; i < TableDepth; i++) begin
        slot_valid[i] = 1'b0;
      end
      mismatches = 0;
      results_seen = 0;
      freed_by_decision = 0;
      foreach (action_seen[i]) action_seen[i] = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [WordW-1:0] data);
      case (idx)
        CFG_NODE_ID:       node_id = data[NodeW-1:0];
        CFG_NUM_NODES:     num_nodes = data[NodesW-1:0];
        CFG_PROPOSE_VALUE: propose_value = data;
        default: ;
      endcase
    endfunction

    // A cluster size of zero counts as one; anything above the maximum is clamped.
    function logic [NodesW-1:0] cluster();
      logic [NodesW-1:0] n;
      n = num_nodes;
      if (n == 0) n = 1;
      if (n > MaxNodes) n = NodesW'(MaxNodes);
      return n;
    endfunction

    function logic [SlotW-1:0] slot_of(logic [WordW-1:0] id);
      return SlotW'(id % TableDepth);
    endfunction

    function bit pending(logic [WordW-1:0] id);
      return slot_valid[slot_of(id)] && slot_id[slot_of(id)] == id;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void note_input(msg_item_t it);
      node_result_t      r;
      logic [NodesW-1:0] n;
      logic [NodesW-1:0] turn;
      logic [SlotW-1:0]  s;
      r = '0;
      r.action = ACT_IDLE;
      n = cluster();
      turn = NodesW'(it.now_ms % WordW'(n));
      s = slot_of(it.msg_proposal_id);
      case (it.op)
        // A tick opens a proposal only in this node's time slot.
        OP_TICK: begin
          if ({1'b0, node_id} == turn) begin
            slot_valid[slot_of(next_id)] = 1'b1;
            slot_id[slot_of(next_id)] = next_id;
            slot_value[slot_of(next_id)] = propose_value;
            slot_acks[slot_of(next_id)] = '0;
            r.action = ACT_BCAST_PROPOSAL;
            r.proposal_id = next_id;
            r.value = propose_value;
            r.stamp_ms = it.now_ms;
            next_id = next_id + 1;
          end
        end
        OP_PROPOSAL: begin
          r.proposal_id = it.msg_proposal_id;
          if ({1'b0, it.sender_id} != turn) begin
            r.action = ACT_DROP_PROPOSER;
          end else begin
            r.action = ACT_SEND_ACCEPT;
            r.dest_node = it.sender_id;
            r.value = it.msg_value;
            r.stamp_ms = it.now_ms;
          end
        end
        // Accepts count toward the quorum; reaching it decides and frees the entry.
        OP_ACCEPT: begin
          r.proposal_id = it.msg_proposal_id;
          if (it.target_node != node_id) begin
            r.action = ACT_DROP_TARGET;
          end else if (!pending(it.msg_proposal_id)) begin
            r.action = ACT_DROP_UNKNOWN;
          end else begin
            slot_acks[s] = slot_acks[s] + 1;
            r.ack_total = slot_acks[s];
            r.value = slot_value[s];
            if (slot_acks[s] >= n / 2) begin
              r.action = ACT_BCAST_DECISION;
              r.stamp_ms = it.now_ms;
              slot_valid[s] = 1'b0;
            end else begin
              r.action = ACT_ACK_COUNTED;
            end
          end
        end
        default: begin
          r.action = ACT_DECISION_RECORDED;
          r.proposal_id = it.msg_proposal_id;
          r.value = it.msg_value;
          r.stamp_ms = it.msg_time;
          if (pending(it.msg_proposal_id)) begin
            slot_valid[s] = 1'b0;
            r.entry_found = 1'b1;
          end
        end
      endcase
      action_q.push_back(r);
    endfunction

    function void check_field(string name, logic [WordW-1:0] got, logic [WordW-1:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got 0x%0h, want 0x%0h", results_seen, name, got, want));
      end
    endfunction

    function void check_result(node_result_t got);
      node_result_t want;
      results_seen++;
      if (action_q.size() == 0) begin
        report($sformatf("result %0d arrived with no item outstanding", results_seen));
        return;
      end
      want = action_q.pop_front();
      if (want.action <= ACT_DROP_UNKNOWN) action_seen[want.action]++;
      if (want.entry_found) freed_by_decision++;
      check_field("action", WordW'(got.action), WordW'(want.action));
      check_field("dest_node", WordW'(got.dest_node), WordW'(want.dest_node));
      check_field("proposal_id", got.proposal_id, want.proposal_id);
      check_field("value", got.value, want.value);
      check_field("stamp_ms", got.stamp_ms, want.stamp_ms);
      check_field("ack_total", WordW'(got.ack_total), WordW'(want.ack_total));
      check_field("entry_found", WordW'(got.entry_found), WordW'(want.entry_found));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [WordW-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [OpW-1:0]    operation;
  logic [WordW-1:0]  now_ms;
  logic [NodeW-1:0]  sender_id;
  logic [NodeW-1:0]  target_node;
  logic [WordW-1:0]  msg_proposal_id;
  logic [WordW-1:0]  msg_value;
  logic [WordW-1:0]  msg_time;
  logic              out_valid;
  logic              out_stall;
  logic [ActW-1:0]   action;
  logic [NodeW-1:0]  dest_node;
  logic [WordW-1:0]  out_proposal_id;
  logic [WordW-1:0]  out_value;
  logic [WordW-1:0]  stamp_ms;
  logic [AckW-1:0]   ack_total;
  logic              entry_found;

  quorum_scoreboard sb = new();
  int unsigned send_idle_pct = 29;
  int unsigned recv_stall_pct = 55;
  int unsigned items_sent = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count = 0;

  consensus_quorum_tracker_top DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .operation_i       (operation),
    .now_ms_i          (now_ms),
    .sender_id_i       (sender_id),
    .target_node_i     (target_node),
    .msg_proposal_id_i (msg_proposal_id),
    .msg_value_i       (msg_value),
    .msg_time_i        (msg_time),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .action_o          (action),
    .dest_node_o       (dest_node),
    .out_proposal_id_o (out_proposal_id),
    .out_value_o       (out_value),
    .stamp_ms_o        (stamp_ms),
    .ack_total_o       (ack_total),
    .entry_found_o     (entry_found)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL consensus_quorum_tracker_top");
      $finish;
    end
  end

  // The receiver stalls at random; the stall changes on the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Every result beat is checked against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    node_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.action = action_e'(action);
      got.dest_node = dest_node;
      got.proposal_id = out_proposal_id;
      got.value = out_value;
      got.stamp_ms = stamp_ms;
      got.ack_total = ack_total;
      got.entry_found = entry_found;
      sb.check_result(got);
    end
  end

  task automatic send_item(input msg_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= it.op;
    now_ms <= it.now_ms;
    sender_id <= it.sender_id;
    target_node <= it.target_node;
    msg_proposal_id <= it.msg_proposal_id;
    msg_value <= it.msg_value;
    msg_time <= it.msg_time;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [WordW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every predicted result has come back and the block is quiet.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.action_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic configure(input logic [NodeW-1:0] node, input logic [NodesW-1:0] nodes,
                           input logic [WordW-1:0] value);
    settle();
    write_reg(CFG_NODE_ID, WordW'(node));
    write_reg(CFG_NUM_NODES, WordW'(nodes));
    write_reg(CFG_PROPOSE_VALUE, value);
    settings_used++;
  endtask

  function automatic msg_item_t any_item();
    msg_item_t it;
    it.op = op_e'($urandom_range(0, 3));
    it.now_ms = $urandom;
    it.sender_id = NodeW'($urandom);
    it.target_node = NodeW'($urandom);
    it.msg_proposal_id = $urandom;
    it.msg_value = $urandom;
    it.msg_time = $urandom;
    return it;
  endfunction

  function automatic msg_item_t mk(op_e op, logic [WordW-1:0] now, logic [NodeW-1:0] sender,
                                   logic [NodeW-1:0] target, logic [WordW-1:0] id,
                                   logic [WordW-1:0] value, logic [WordW-1:0] stamp);
    msg_item_t it;
    it.op = op;
    it.now_ms = now;
    it.sender_id = sender;
    it.target_node = target;
    it.msg_proposal_id = id;
    it.msg_value = value;
    it.msg_time = stamp;
    return it;
  endfunction

  // A time that falls in the slot of the given node, anywhere in the 32-bit range.
  function automatic logic [WordW-1:0] time_in_turn(int unsigned owner);
    longint unsigned base;
    longint unsigned n;
    n = sb.cluster();
    base = $urandom;
    base = base - base % n + owner;
    if (base > 64'hFFFF_FFFF) base = base - n;
    return base[WordW-1:0];
  endfunction

  // Mostly the newest proposal, sometimes an older or an overwritten one.
  function automatic logic [WordW-1:0] recent_id();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (sb.next_id == 0) return $urandom;
    if (pick < 55) return sb.next_id - 1;
    if (pick < 85) return sb.next_id - 1 - $urandom_range(1, 7);
    return sb.next_id - 1 - $urandom_range(8, 24);
  endfunction

  // One round: an opening tick and a run of accepts, with some decisions mixed in, on recent ids.
  task automatic quorum_round();
    msg_item_t   it;
    int unsigned acks;
    it = any_item();
    it.op = OP_TICK;
    if (sb.node_id < sb.cluster()) it.now_ms = time_in_turn(sb.node_id);
    send_item(it);
    acks = $urandom_range(1, sb.cluster() / 2 + 1);
    repeat (acks) begin
      it = any_item();
      it.op = ($urandom_range(0, 99) < 8) ? OP_DECISION : OP_ACCEPT;
      if ($urandom_range(0, 99) < 92) it.target_node = sb.node_id;
      it.msg_proposal_id = recent_id();
      send_item(it);
    end
  endtask

  task automatic single_item();
    msg_item_t   it;
    int unsigned pick;
    it = any_item();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.op = OP_TICK;
      if (sb.node_id < sb.cluster() && $urandom_range(0, 99) < 70) begin
        it.now_ms = time_in_turn(sb.node_id);
      end
    end else if (pick < 45) begin
      it.op = OP_PROPOSAL;
      if ($urandom_range(0, 99) < 70) it.sender_id = NodeW'(it.now_ms % sb.cluster());
    end else if (pick < 75) begin
      it.op = OP_ACCEPT;
      if ($urandom_range(0, 99) < 80) it.target_node = sb.node_id;
      if ($urandom_range(0, 99) < 80) it.msg_proposal_id = recent_id();
    end else begin
      it.op = OP_DECISION;
      if ($urandom_range(0, 99) < 60) it.msg_proposal_id = recent_id();
    end
    send_item(it);
  endtask

  task automatic directed_items();
    // Default settings: one node, so every tick opens and the first ack decides.
    send_item(mk(OP_TICK, 32'h0, 4'h0, 4'h0, 32'h0, 32'h0, 32'h0));
    send_item(mk(OP_TICK, 32'hFFFF_FFFF, 4'hF, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF));
    send_item(mk(OP_ACCEPT, 32'h1234, 4'h3, 4'h0, 32'h0, 32'h0, 32'h0));
    send_item(mk(OP_ACCEPT, 32'h1235, 4'h3, 4'h0, 32'h0, 32'h0, 32'h0));
    send_item(mk(OP_ACCEPT, 32'h1236, 4'h0, 4'hF, 32'h1, 32'h0, 32'h0));
    send_item(mk(OP_DECISION, 32'h0, 4'h0, 4'h0, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk(OP_DECISION, 32'hFFFF_FFFF, 4'hF, 4'hF, 32'h1, 32'h0, 32'h0));
    send_item(mk(OP_PROPOSAL, 32'h5, 4'h0, 4'h9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h77));
    send_item(mk(OP_PROPOSAL, 32'h5, 4'hF, 4'h0, 32'h8, 32'h9, 32'h0));
    // Stale accept: its slot is empty.
    send_item(mk(OP_ACCEPT, 32'h0, 4'h0, 4'h0, 32'h11, 32'h0, 32'h0));

    // Zero cluster size behaves as a single node.
    configure(4'h0, 5'd0, 32'h0);
    send_item(mk(OP_TICK, 32'h7, 4'h0, 4'h0, 32'h0, 32'h0, 32'h0));

    // Oversized cluster is clamped to the maximum; last node owns slot 15.
    configure(4'hF, 5'd31, 32'hFFFF_FFFF);
    send_item(mk(OP_TICK, 32'hF, 4'h0, 4'h0, 32'h0, 32'h0, 32'h0));
    send_item(mk(OP_TICK, 32'h10, 4'h0, 4'h0, 32'h0, 32'h0, 32'h0));
    send_item(mk(OP_PROPOSAL, 32'hFFFF_FFFF, 4'hF, 4'h0, 32'h3, 32'h5, 32'h0));
    repeat (8) send_item(mk(OP_ACCEPT, 32'hABCD, 4'h2, 4'hF, 32'h3, 32'h0, 32'h0));
    send_item(mk(OP_ACCEPT, 32'hABCE, 4'h2, 4'hF, 32'h13, 32'h0, 32'h0));
  endtask

  initial begin : stimulus
    logic [NodeW-1:0]  node_cfg[9];
    logic [NodesW-1:0] size_cfg[9];
    logic [WordW-1:0]  value_cfg[9];
    int unsigned       phase_start;
    int unsigned       waited;
    node_cfg = '{4'd3, 4'd0, 4'd15, 4'd2, 4'd7, 4'd1, 4'd9, 4'd0, 4'd4};
    size_cfg = '{5'd5, 5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd2, 5'd8};
    value_cfg = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};

    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NODE_ID;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_TICK;
    now_ms = '0;
    sender_id = '0;
    target_node = '0;
    msg_proposal_id = '0;
    msg_value = '0;
    msg_time = '0;
    out_stall = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    directed_items();

    // Random phases: three per handshake pressure mode.
    for (int p = 0; p < 9; p++) begin
      send_idle_pct = (p < 3) ? 29 : (p < 6) ? 55 : 0;
      recv_stall_pct = (p < 3) ? 55 : (p < 6) ? 29 : 0;
      if (p != 1 && p != 2) value_cfg[p] = $urandom;
      configure(node_cfg[p], size_cfg[p], value_cfg[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(0, 99) < 35) quorum_round();
        else single_item();
      end
    end

    // Final drain, bounded so that a lost result shows up as a failure.
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (sb.action_q.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.action_q.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.action_q.size()));
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d items under %0d register settings and three stall mixes.",
             items_sent, settings_used);
    $display("Saw %0d proposals, %0d accepts, %0d acks, %0d decisions, %0d recorded (%0d freed).",
             sb.action_seen[ACT_BCAST_PROPOSAL], sb.action_seen[ACT_SEND_ACCEPT],
             sb.action_seen[ACT_ACK_COUNTED], sb.action_seen[ACT_BCAST_DECISION],
             sb.action_seen[ACT_DECISION_RECORDED], sb.freed_by_decision);
    if (sb.mismatches == 0) begin
      $display("PASS consensus_quorum_tracker_top");
    end else begin
      $display("FAIL consensus_quorum_tracker_top");
    end
    $finish;
  end

endmodule
